@@ hw/rtl/bpbe_pkg.sv @@
// package for the packet body bit encoder: item types, codes and constants
// shared by the front, queue and back; no dependencies
`default_nettype none

package bpbe_pkg;

    localparam int CRC_W      = 24;
    localparam int WHT_W      = 7;
    localparam int CHAN_W     = 6;
    localparam int HIST_W     = 3;
    localparam int CHIP_W     = 16;
    localparam int CNT_W      = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = 5;
    localparam int FLUSH_STEPS = 3;

    localparam logic [CRC_W-1:0] CRC_TAPS     = 24'h00065A;
    localparam logic [CRC_W-1:0] CRC_INIT_RST = 24'h555555;
    localparam logic [WHT_W-1:0] WHT_TAP      = 7'h10;

    localparam logic [MODE_W-1:0] MODE_UNCODED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPREAD2 = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHY_MODE = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_UNCODED = 5'd1;
    localparam logic [CNT_W-1:0] COUNT_SPREAD2 = 5'd4;
    localparam logic [CNT_W-1:0] COUNT_SPREAD8 = 5'd16;

    typedef enum logic [1:0] {
        S_DATA,
        S_CRC,
        S_FLUSH
    } t_back_state;

    // one queued pdu bit, with the finished crc riding along on the last one
    typedef struct packed {
        logic             data_bit;
        logic             last_bit;
        logic             start;
        logic [CRC_W-1:0] crc;
    } t_q_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic [CHIP_W-1:0] chips;
        logic [CNT_W-1:0]  count;
        logic [HIST_W-1:0] hist;
    } t_enc_out;

    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic b);
        logic fb;
        fb = b ^ crc[CRC_W-1];
        return {crc[CRC_W-2:0], fb} ^ (fb ? CRC_TAPS : '0);
    endfunction

    // position 0 holds a one, channel msb lands at position 1
    function automatic logic [WHT_W-1:0] wht_seed(input logic [CHAN_W-1:0] ch);
        logic [WHT_W-1:0] s;
        s[0] = 1'b1;
        for (int i = 0; i < CHAN_W; i++) begin
            s[i+1] = ch[CHAN_W-1-i];
        end
        return s;
    endfunction

    function automatic logic [WHT_W-1:0] wht_next(input logic [WHT_W-1:0] w);
        logic fb;
        fb = w[WHT_W-1];
        return {w[WHT_W-2:0], fb} ^ (fb ? WHT_TAP : '0);
    endfunction

    // coded modes: rate-1/2 k=4 code, g0 mask 0xf, g1 mask 0xb, then repetition; uncoded passes the bit
    function automatic t_enc_out encode(input logic [MODE_W-1:0] mode,
                                        input logic [HIST_W-1:0] hist,
                                        input logic b);
        t_enc_out r;
        logic [HIST_W:0] w;
        logic g0;
        logic g1;
        w  = {hist, b};
        g0 = ^w;
        g1 = w[0] ^ w[1] ^ w[3];
        if (mode[1]) begin
            r.chips = {{8{g1}}, {8{g0}}};
            r.count = COUNT_SPREAD8;
            r.hist  = w[HIST_W-1:0];
        end else if (mode == MODE_SPREAD2) begin
            r.chips = {12'd0, g1, g1, g0, g0};
            r.count = COUNT_SPREAD2;
            r.hist  = w[HIST_W-1:0];
        end else begin
            r.chips = {15'd0, b};
            r.count = COUNT_UNCODED;
            r.hist  = hist;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ble_packet_body_bit_encoder.sv @@
// packet body bit encoder: crc-24, whitening and coded phy repetition
// an accepted item passes through the two-entry queue and the back end result register
// one pdu bit per cycle while the queue has room and results are popped; the last bit
// of a packet yields 25 results (uncoded) or 28 (coded), one a cycle from the back end
// tail sequencer while results are popped, and input stalls once the two-entry queue fills during that tail
// reset: synchronous active low; config and control registers reset, queue empties
`default_nettype none

module ble_packet_body_bit_encoder import bpbe_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 i_data_bit,
    input  wire logic                 i_last_bit,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [CHIP_W-1:0]         o_chips,
    output logic [CNT_W-1:0]          o_chip_count,
    output logic                      o_packet_end,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CRC_W-1:0]     i_cfg_data
);

    logic [CHAN_W-1:0] r_channel_index;
    logic [CRC_W-1:0]  r_crc_init;
    logic [MODE_W-1:0] r_phy_mode;

    t_q_status q_status;
    t_q_entry  q_in;
    t_q_entry  q_out;
    logic      q_push;
    logic      q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_index <= '0;
            r_crc_init      <= CRC_INIT_RST;
            r_phy_mode      <= MODE_UNCODED;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHANNEL:  r_channel_index <= i_cfg_data[CHAN_W-1:0];
                CFG_CRC_INIT: r_crc_init      <= i_cfg_data;
                CFG_PHY_MODE: r_phy_mode      <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    bpbe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_data_bit (i_data_bit),
        .i_last_bit (i_last_bit),
        .i_crc_init (r_crc_init),
        .i_q_status (q_status),
        .o_q_push   (q_push),
        .o_q_entry  (q_in)
    );

    bpbe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (q_in),
        .i_pop    (q_pop),
        .o_entry  (q_out),
        .o_status (q_status)
    );

    bpbe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_channel_index (r_channel_index),
        .i_phy_mode      (r_phy_mode),
        .i_q_entry       (q_out),
        .i_q_status      (q_status),
        .o_q_pop         (q_pop),
        .empty           (empty),
        .pop             (pop),
        .o_chips         (o_chips),
        .o_chip_count    (o_chip_count),
        .o_packet_end    (o_packet_end)
    );

endmodule

`default_nettype wire

@@ hw/rtl/bpbe_front.sv @@
// front end: accepts pdu bits, runs the crc-24 and marks packet starts
// depends on bpbe_pkg
`default_nettype none

module bpbe_front import bpbe_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic             i_data_bit,
    input  wire logic             i_last_bit,
    input  wire logic [CRC_W-1:0] i_crc_init,
    input  wire t_q_status        i_q_status,
    output logic                  o_q_push,
    output t_q_entry              o_q_entry
);

    logic             r_pending;
    logic             n_pending;
    logic [CRC_W-1:0] r_crc;
    logic [CRC_W-1:0] n_crc;
    logic [CRC_W-1:0] crc_cur;

    assign full     = i_q_status.full;
    assign o_q_push = push && !i_q_status.full;

    always_comb begin
        crc_cur   = r_pending ? i_crc_init : r_crc;
        n_crc     = r_crc;
        n_pending = r_pending;
        if (o_q_push) begin
            n_crc     = crc_step(crc_cur, i_data_bit);
            n_pending = i_last_bit;
        end
    end

    always_comb begin
        o_q_entry.data_bit = i_data_bit;
        o_q_entry.last_bit = i_last_bit;
        o_q_entry.start    = r_pending;
        o_q_entry.crc      = crc_step(crc_cur, i_data_bit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b1;
        end else begin
            r_pending <= n_pending;
        end
        r_crc <= n_crc;
    end

endmodule

`default_nettype wire

@@ hw/rtl/bpbe_queue.sv @@
// two-entry item queue between front and back
// depends on bpbe_pkg
`default_nettype none

module bpbe_queue import bpbe_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_q_entry i_entry,
    input  wire logic     i_pop,
    output t_q_entry      o_entry,
    output t_q_status     o_status
);

    t_q_entry   r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_entry        = r_mem[r_rd];
    assign o_status.empty = (r_cnt == 2'd0);
    assign o_status.full  = (r_cnt == 2'd2);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bpbe_back.sv @@
// back end: whitening, convolutional coding and the crc and flush tail,
// with the result register; depends on bpbe_pkg
`default_nettype none

module bpbe_back import bpbe_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CHAN_W-1:0] i_channel_index,
    input  wire logic [MODE_W-1:0] i_phy_mode,
    input  wire t_q_entry          i_q_entry,
    input  wire t_q_status         i_q_status,
    output logic                   o_q_pop,
    output logic                   empty,
    input  wire logic              pop,
    output logic [CHIP_W-1:0]      o_chips,
    output logic [CNT_W-1:0]       o_chip_count,
    output logic                   o_packet_end
);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [CRC_W-1:0]  r_crc;
    logic [CRC_W-1:0]  n_crc;
    logic [WHT_W-1:0]  r_wht;
    logic [WHT_W-1:0]  n_wht;
    logic [HIST_W-1:0] r_hist;
    logic [HIST_W-1:0] n_hist;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [CHIP_W-1:0] r_chips;
    logic [CNT_W-1:0]  r_count;
    logic              r_end;

    logic              out_free;
    logic              emit;
    logic              emit_end;
    logic              enc_bit;
    logic [WHT_W-1:0]  wht_cur;
    logic [HIST_W-1:0] hist_cur;
    t_enc_out          enc;

    assign out_free = !r_out_valid || pop;

    // next state and tail sequencing
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_crc   = r_crc;
        unique case (r_state)
            S_DATA: begin
                if (out_free && !i_q_status.empty && i_q_entry.last_bit) begin
                    n_state = S_CRC;
                    n_step  = '0;
                    n_crc   = i_q_entry.crc;
                end
            end
            S_CRC: begin
                if (out_free) begin
                    n_crc  = r_crc >> 1;
                    n_step = r_step + 1'b1;
                    if (r_step == STEP_W'(CRC_W - 1)) begin
                        n_step  = '0;
                        n_state = (i_phy_mode != MODE_UNCODED) ? S_FLUSH : S_DATA;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_step = r_step + 1'b1;
                    if (r_step == STEP_W'(FLUSH_STEPS - 1)) begin
                        n_state = S_DATA;
                    end
                end
            end
            default: n_state = S_DATA;
        endcase
    end

    // datapath controls per state
    always_comb begin
        o_q_pop  = 1'b0;
        emit     = 1'b0;
        emit_end = 1'b0;
        wht_cur  = r_wht;
        hist_cur = r_hist;
        enc_bit  = 1'b0;
        n_wht    = r_wht;
        unique case (r_state)
            S_DATA: begin
                o_q_pop = out_free && !i_q_status.empty;
                emit    = o_q_pop;
                if (i_q_entry.start) begin
                    wht_cur  = wht_seed(i_channel_index);
                    hist_cur = '0;
                end
                enc_bit = i_q_entry.data_bit ^ wht_cur[WHT_W-1];
                if (emit) begin
                    n_wht = wht_next(wht_cur);
                end
            end
            S_CRC: begin
                emit     = out_free;
                emit_end = (r_step == STEP_W'(CRC_W - 1)) && (i_phy_mode == MODE_UNCODED);
                enc_bit  = r_crc[0] ^ r_wht[WHT_W-1];
                if (emit) begin
                    n_wht = wht_next(r_wht);
                end
            end
            S_FLUSH: begin
                // flush zeros bypass the whitening
                emit     = out_free;
                emit_end = (r_step == STEP_W'(FLUSH_STEPS - 1));
                enc_bit  = 1'b0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        enc         = encode(i_phy_mode, hist_cur, enc_bit);
        n_hist      = emit ? enc.hist : r_hist;
        n_out_valid = emit || (r_out_valid && !pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_DATA;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_crc  <= n_crc;
        r_wht  <= n_wht;
        r_hist <= n_hist;
        if (emit) begin
            r_chips <= enc.chips;
            r_count <= enc.count;
            r_end   <= emit_end;
        end
    end

    assign empty        = !r_out_valid;
    assign o_chips      = r_chips;
    assign o_chip_count = r_count;
    assign o_packet_end = r_end;

    a_crc_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CRC |-> r_step <= STEP_W'(CRC_W - 1))
        else $error("crc step counter out of range");

    a_flush_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FLUSH |-> r_step <= STEP_W'(FLUSH_STEPS - 1))
        else $error("flush step counter out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !i_q_status.empty && r_state == S_DATA)
        else $error("queue popped while empty or in the tail");

    a_end_from_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && emit_end |=> r_state == S_DATA && o_packet_end)
        else $error("packet end did not close the tail");

    a_tail_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_DATA |-> !o_q_pop)
        else $error("queue drained during packet tail");

endmodule

`default_nettype wire
